// ===== hw/rtl/bpsu_pkg.sv =====
// shared types and constants of the bingham plastic shrinkage update block
package bpsu_pkg;

  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;
  // front stages, root stages, fraction divider, multiply, shrink divider, tail
  localparam int unsigned PIPE_DEPTH = 3 + (ROOT_STEPS + 1) + (DIV_STEPS + 1) + 1
                                       + (DIV_STEPS + 1) + 3;

  localparam logic KIND_CENTER = 1'b0;
  localparam logic KIND_NODE   = 1'b1;

  typedef enum logic [1:0] {
    REG_PENALTY_R = 2'd0,
    REG_VISCOSITY = 2'd1,
    REG_YIELD     = 2'd2,
    REG_STEP_RHO  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] txx;
    logic [31:0] tyy;
    logic [31:0] txy;
    logic [31:0] exx;
    logic [31:0] eyy;
    logic [31:0] ssum;
    logic [31:0] t11;
    logic [31:0] t22;
    logic [31:0] t12;
    logic [31:0] norm;
    logic        yld;
  } ctx_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] low;
    logic [31:0] q;
  } dv_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } shr_flags_t;

endpackage

// ===== hw/rtl/bingham_plastic_shrinkage_update.sv =====
// Bingham plastic shrinkage update: one grid point per cycle through 106 register stages.
// Each point passes three front stages (penalty products, trial stresses,
// squares), a 33-stage square root of the 64-bit sum of squares, a 33-stage
// divider for the shrink fraction, one multiply stage, a 33-stage divider by
// r + mu for two lanes, and three tail stages (plastic strains, strain mismatch
// products, update and saturation). A new transaction is taken every cycle; the
// pipeline depth is set by the root and the two dividers, which retire one bit per
// stage. When the output is not taken the whole pipeline holds. Write the registers
// only while no transaction is in flight.
module bingham_plastic_shrinkage_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mult_xx, mult_yy, mult_xy, strain_xx, strain_yy, shear_sum
  input  logic [191:0] s_tdata,
  // point_kind
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // plastic_xx, plastic_yy, plastic_xy, new_mult_xx, new_mult_yy, new_mult_xy,
  // trial_norm, yielded, residual, zero pad
  output logic [255:0] m_tdata
);

  localparam int unsigned NR = bpsu_pkg::ROOT_STEPS;
  localparam int unsigned ND = bpsu_pkg::DIV_STEPS;
  localparam int unsigned NP = bpsu_pkg::PIPE_DEPTH;

  logic [30:0] penalty_r, viscosity, yield_stress, step_rho;
  logic        ce;
  logic [NP-1:0] vld;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] tau, input logic [50:0] m,
                                          input logic neg);
    logic signed [52:0] s;
    s = $signed({{21{tau[31]}}, tau}) + (neg ? -$signed({2'b00, m}) : $signed({2'b00, m}));
    if (s > 53'sd2147483647) add_sat = 32'h7fff_ffff;
    else if (s < -53'sd2147483648) add_sat = 32'h8000_0000;
    else add_sat = s[31:0];
  endfunction

  function automatic bpsu_pkg::sq_t sq_step(input bpsu_pkg::sq_t s);
    bpsu_pkg::sq_t o;
    logic [33:0]   r2, trial;
    r2    = {s.rem[31:0], s.rad[63:62]};
    trial = {s.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[30:0], 1'b0};
    end
    o.rad = {s.rad[61:0], 2'b00};
    sq_step = o;
  endfunction

  function automatic bpsu_pkg::dv_t dv_step(input bpsu_pkg::dv_t s);
    bpsu_pkg::dv_t o;
    logic [32:0]   r2;
    r2    = {s.rem, s.low[31]};
    o.den = s.den;
    o.low = {s.low[30:0], 1'b0};
    if (r2 >= {1'b0, s.den}) begin
      o.rem = 32'(r2 - {1'b0, s.den});
      o.q   = {s.q[30:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.q   = {s.q[30:0], 1'b0};
    end
    dv_step = o;
  endfunction

  function automatic logic [30:0] sat31(input logic [33:0] v);
    sat31 = (v[33:31] != 3'b000) ? 31'h7fff_ffff : v[30:0];
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      penalty_r    <= 31'd65536;
      viscosity    <= 31'd65536;
      yield_stress <= 31'd0;
      step_rho     <= 31'd65536;
    end else if (cfg_we) begin
      unique case (bpsu_pkg::cfg_reg_t'(cfg_index))
        bpsu_pkg::REG_PENALTY_R: penalty_r    <= cfg_data;
        bpsu_pkg::REG_VISCOSITY: viscosity    <= cfg_data;
        bpsu_pkg::REG_YIELD:     yield_stress <= cfg_data;
        bpsu_pkg::REG_STEP_RHO:  step_rho     <= cfg_data;
      endcase
    end
  end

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[NP-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NP-2:0], s_tvalid};
    end
  end

  // stage a: penalty products
  bpsu_pkg::ctx_t a_ctx, a_ctx_next;
  logic [62:0]    a_p11, a_p22, a_p12;
  always_comb begin
    a_ctx_next      = '0;
    a_ctx_next.kind = s_tuser[0];
    a_ctx_next.txx  = s_tdata[31:0];
    a_ctx_next.tyy  = s_tdata[63:32];
    a_ctx_next.txy  = s_tdata[95:64];
    a_ctx_next.exx  = s_tdata[127:96];
    a_ctx_next.eyy  = s_tdata[159:128];
    a_ctx_next.ssum = s_tdata[191:160];
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      a_ctx <= a_ctx_next;
      a_p11 <= 63'(mag32(s_tdata[127:96])) * 63'(penalty_r);
      a_p22 <= 63'(mag32(s_tdata[159:128])) * 63'(penalty_r);
      a_p12 <= 63'(mag32(s_tdata[191:160])) * 63'(penalty_r);
    end
  end

  // stage b: trial stresses
  bpsu_pkg::ctx_t b_ctx, b_ctx_next;
  always_comb begin
    b_ctx_next     = a_ctx;
    b_ctx_next.t11 = add_sat(a_ctx.txx, {3'b000, a_p11[62:15]}, a_ctx.exx[31]);
    b_ctx_next.t22 = add_sat(a_ctx.tyy, {3'b000, a_p22[62:15]}, a_ctx.eyy[31]);
    b_ctx_next.t12 = add_sat(a_ctx.txy, {4'b0000, a_p12[62:16]}, a_ctx.ssum[31]);
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      b_ctx <= b_ctx_next;
    end
  end

  // stage c: squares
  bpsu_pkg::ctx_t c_ctx;
  logic [63:0]    c_s11, c_s22, c_s12;
  always_ff @(posedge clk) begin
    if (ce) begin
      c_ctx <= b_ctx;
      c_s11 <= 64'(mag32(b_ctx.t11)) * 64'(mag32(b_ctx.t11));
      c_s22 <= 64'(mag32(b_ctx.t22)) * 64'(mag32(b_ctx.t22));
      c_s12 <= 64'(mag32(b_ctx.t12)) * 64'(mag32(b_ctx.t12));
    end
  end

  // square root stages, entry stage saturates the sum of squares
  logic [65:0]    tot;
  bpsu_pkg::sq_t  sq [0:NR];
  bpsu_pkg::ctx_t sq_ctx [0:NR];
  assign tot = 66'(c_s11) + 66'(c_s22) + {1'b0, c_s12, 1'b0};
  always_ff @(posedge clk) begin
    if (ce) begin
      sq_ctx[0] <= c_ctx;
      sq[0]     <= '{rem: 34'd0, root: 32'd0,
                     rad: (tot[65:64] != 2'b00) ? {64{1'b1}} : tot[63:0]};
      for (int k = 0; k < NR; k++) begin
        sq[k+1]     <= sq_step(sq[k]);
        sq_ctx[k+1] <= sq_ctx[k];
      end
    end
  end

  // fraction divider: ((n - y) << 31) / n
  logic [31:0]    nrm, ndiff;
  logic           nyld;
  bpsu_pkg::dv_t  fd [0:ND];
  bpsu_pkg::ctx_t fd_ctx [0:ND];
  bpsu_pkg::ctx_t fd_ctx_next;
  logic           fd_zero [0:ND];
  assign nrm   = sq[NR].root;
  assign nyld  = nrm >= {1'b0, yield_stress};
  assign ndiff = nrm - {1'b0, yield_stress};
  always_comb begin
    fd_ctx_next      = sq_ctx[NR];
    fd_ctx_next.norm = nrm;
    fd_ctx_next.yld  = nyld;
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      fd_ctx[0]  <= fd_ctx_next;
      fd_zero[0] <= !nyld || (nrm == 32'd0);
      fd[0]      <= '{rem: nyld ? {1'b0, ndiff[31:1]} : 32'd0, den: nrm,
                      low: {ndiff[0], 31'd0}, q: 32'd0};
      for (int k = 0; k < ND; k++) begin
        fd[k+1]      <= dv_step(fd[k]);
        fd_ctx[k+1]  <= fd_ctx[k];
        fd_zero[k+1] <= fd_zero[k];
      end
    end
  end

  // stage f: trial stress times fraction, lane 0 is xx or xy, lane 1 is yy
  logic [31:0]    frac, lane_t0;
  bpsu_pkg::ctx_t f_ctx;
  logic [63:0]    f_p0, f_p1;
  assign frac    = fd_zero[ND] ? '0 : fd[ND].q;
  assign lane_t0 = (fd_ctx[ND].kind == bpsu_pkg::KIND_NODE) ? fd_ctx[ND].t12 : fd_ctx[ND].t11;
  always_ff @(posedge clk) begin
    if (ce) begin
      f_ctx <= fd_ctx[ND];
      f_p0  <= 64'(mag32(lane_t0)) * 64'(frac);
      f_p1  <= 64'(mag32(fd_ctx[ND].t22)) * 64'(frac);
    end
  end

  // shrink divider: (|a| << 15) / (r + mu), two lanes
  logic [31:0]          amag0, amag1, den, lane_f0;
  bpsu_pkg::dv_t        dv0 [0:ND];
  bpsu_pkg::dv_t        dv1 [0:ND];
  bpsu_pkg::shr_flags_t fl0 [0:ND];
  bpsu_pkg::shr_flags_t fl1 [0:ND];
  bpsu_pkg::ctx_t       dv_ctx [0:ND];
  assign amag0   = f_p0[62:31];
  assign amag1   = f_p1[62:31];
  assign den     = 32'(penalty_r) + 32'(viscosity);
  assign lane_f0 = (f_ctx.kind == bpsu_pkg::KIND_NODE) ? f_ctx.t12 : f_ctx.t11;
  always_ff @(posedge clk) begin
    if (ce) begin
      dv_ctx[0] <= f_ctx;
      dv0[0]    <= '{rem: {17'd0, amag0[31:17]}, den: den,
                     low: {amag0[16:0], 15'd0}, q: 32'd0};
      dv1[0]    <= '{rem: {17'd0, amag1[31:17]}, den: den,
                     low: {amag1[16:0], 15'd0}, q: 32'd0};
      fl0[0]    <= '{neg: lane_f0[31], zero: amag0 == 32'd0,
                     ovf: {17'd0, amag0[31:17]} >= den};
      fl1[0]    <= '{neg: f_ctx.t22[31], zero: amag1 == 32'd0,
                     ovf: {17'd0, amag1[31:17]} >= den};
      for (int k = 0; k < ND; k++) begin
        dv0[k+1]    <= dv_step(dv0[k]);
        dv1[k+1]    <= dv_step(dv1[k]);
        fl0[k+1]    <= fl0[k];
        fl1[k+1]    <= fl1[k];
        dv_ctx[k+1] <= dv_ctx[k];
      end
    end
  end

  function automatic logic [31:0] gamma_of(input logic [31:0] q,
                                           input bpsu_pkg::shr_flags_t f);
    if (f.zero) gamma_of = '0;
    else if (f.ovf || q[31]) gamma_of = f.neg ? 32'h8000_0000 : 32'h7fff_ffff;
    else gamma_of = f.neg ? 32'(-q) : q;
  endfunction

  // stage h: plastic strains
  bpsu_pkg::ctx_t h_ctx;
  logic [31:0]    h_g0, h_g1;
  always_ff @(posedge clk) begin
    if (ce) begin
      h_ctx <= dv_ctx[ND];
      h_g0  <= gamma_of(dv0[ND].q, fl0[ND]);
      h_g1  <= gamma_of(dv1[ND].q, fl1[ND]);
    end
  end

  // stage i: strain mismatch times rho
  logic signed [33:0] d0, d1;
  logic [33:0]        m0, m1;
  bpsu_pkg::ctx_t     i_ctx;
  logic [31:0]        i_g0, i_g1;
  logic [33:0]        i_m0, i_m1;
  logic               i_n0, i_n1;
  logic [64:0]        i_p0, i_p1;
  always_comb begin
    if (h_ctx.kind == bpsu_pkg::KIND_NODE) begin
      d0 = $signed({{2{h_ctx.ssum[31]}}, h_ctx.ssum}) - $signed({h_g0[31], h_g0, 1'b0});
      d1 = '0;
    end else begin
      d0 = $signed({{2{h_ctx.exx[31]}}, h_ctx.exx}) - $signed({{2{h_g0[31]}}, h_g0});
      d1 = $signed({{2{h_ctx.eyy[31]}}, h_ctx.eyy}) - $signed({{2{h_g1[31]}}, h_g1});
    end
    m0 = d0[33] ? 34'(-d0) : 34'(d0);
    m1 = d1[33] ? 34'(-d1) : 34'(d1);
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      i_ctx <= h_ctx;
      i_g0  <= h_g0;
      i_g1  <= h_g1;
      i_m0  <= m0;
      i_m1  <= m1;
      i_n0  <= d0[33];
      i_n1  <= d1[33];
      i_p0  <= 65'(m0) * 65'(step_rho);
      i_p1  <= 65'(m1) * 65'(step_rho);
    end
  end

  // stage j: multiplier update, residual, output register
  logic [31:0] j_pxx, j_pyy, j_pxy, j_nxx, j_nyy, j_nxy;
  logic [30:0] j_norm, j_res;
  logic        j_yld;
  always_ff @(posedge clk) begin
    if (ce) begin
      j_norm <= i_ctx.norm[31] ? 31'h7fff_ffff : i_ctx.norm[30:0];
      j_yld  <= i_ctx.yld;
      if (i_ctx.kind == bpsu_pkg::KIND_NODE) begin
        j_pxx <= '0;
        j_pyy <= '0;
        j_pxy <= i_g0;
        j_nxx <= '0;
        j_nyy <= '0;
        j_nxy <= add_sat(i_ctx.txy, {2'b00, i_p0[64:16]}, i_n0);
        j_res <= sat31({1'b0, i_m0[33:1]});
      end else begin
        j_pxx <= i_g0;
        j_pyy <= i_g1;
        j_pxy <= '0;
        j_nxx <= add_sat(i_ctx.txx, {1'b0, i_p0[64:15]}, i_n0);
        j_nyy <= add_sat(i_ctx.tyy, {1'b0, i_p1[64:15]}, i_n1);
        j_nxy <= '0;
        j_res <= sat31((i_m0 > i_m1) ? i_m0 : i_m1);
      end
    end
  end

  assign m_tdata = {1'b0, j_res, j_yld, j_norm, j_nxy, j_nyy, j_nxx, j_pxy, j_pyy, j_pxx};

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the bingham plastic shrinkage update block
module tb;

  typedef struct {
    logic        kind;
    logic [31:0] txx, tyy, txy, exx, eyy, ssum;
  } point_t;

  typedef struct packed {
    logic [31:0] gxx, gyy, gxy, nxx, nyy, nxy;
    logic [30:0] norm;
    logic        yld;
    logic [30:0] resid;
  } result_t;

  typedef struct {
    point_t p;
    bit     zero_known;
  } stim_row_t;

  localparam logic [31:0] PMAX = 32'h7fffffff;
  localparam logic [31:0] NMAX = 32'h80000000;
  localparam int unsigned STALL_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = bpsu_pkg::REG_PENALTY_R;
  logic [30:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  wire          s_tready;
  logic [191:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  wire          m_tvalid;
  logic         m_tready = 1'b0;
  wire  [255:0] m_tdata;

  longint unsigned r_val = 65536, mu_val = 65536, yld_val = 0, rho_val = 65536;
  result_t pending_updates[$];
  int      fails = 0;
  bit      sink_on = 1'b0;
  bit      no_idle = 1'b0;
  int      quiet_cycles = 0;

  stim_row_t dir_tab[] = '{
    '{'{bpsu_pkg::KIND_CENTER, 0, 0, 0, 0, 0, 0}, 1'b1},
    '{'{bpsu_pkg::KIND_NODE, 0, 0, 0, 0, 0, 0}, 1'b1},
    '{'{bpsu_pkg::KIND_CENTER, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1'b0},
    '{'{bpsu_pkg::KIND_CENTER, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX}, 1'b0},
    '{'{bpsu_pkg::KIND_NODE, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}, 1'b0},
    '{'{bpsu_pkg::KIND_NODE, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX}, 1'b0},
    '{'{bpsu_pkg::KIND_CENTER, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX}, 1'b0},
    '{'{bpsu_pkg::KIND_NODE, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX}, 1'b0},
    '{'{bpsu_pkg::KIND_CENTER, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
        32'haaaaaaaa, 32'h55555555}, 1'b0},
    '{'{bpsu_pkg::KIND_NODE, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
        32'h55555555, 32'haaaaaaaa}, 1'b0},
    '{'{bpsu_pkg::KIND_CENTER, 0, 0, 0, 32'h00010000, 32'hffff0000, 32'h00020000}, 1'b0},
    '{'{bpsu_pkg::KIND_NODE, 32'h00030000, 32'hfffd0000, 32'h00008000, 0, 0, 0}, 1'b0},
    '{'{bpsu_pkg::KIND_CENTER, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        32'hffffffff, 32'hffffffff}, 1'b0},
    '{'{bpsu_pkg::KIND_NODE, 32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001,
        32'h00000001, 32'h00000001}, 1'b0}
  };

  bingham_plastic_shrinkage_update i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint scale_shift(longint a, longint unsigned b, int sh);
    longint unsigned q;
    q = (magnitude(a) * b) >> sh;
    return a < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint shrink_strain(longint t, longint unsigned frac,
                                           longint unsigned den);
    longint a;
    longint unsigned q;
    a = scale_shift(t, frac, 31);
    if (a == 0) return 0;
    if (den == 0) return a < 0 ? -64'sd2147483648 : 64'sd2147483647;
    q = (magnitude(a) << 15) / den;
    if (q > 64'd4294967296) q = 64'd4294967296;
    return sat_s32(a < 0 ? -longint'(q) : longint'(q));
  endfunction

  function automatic result_t shrinkage_update(point_t p);
    result_t u;
    longint txx, tyy, txy, exx, eyy, ss, t11, t22, t12;
    longint g11, g22, g12, d11, d22, e, nm11, nm22, nm12;
    longint unsigned sq, c2, tot, n, frac, den, resid;
    bit yld;
    txx = longint'($signed(p.txx)); tyy = longint'($signed(p.tyy));
    txy = longint'($signed(p.txy)); exx = longint'($signed(p.exx));
    eyy = longint'($signed(p.eyy)); ss = longint'($signed(p.ssum));
    t11 = sat_s32(txx + scale_shift(exx, r_val, 15));
    t22 = sat_s32(tyy + scale_shift(eyy, r_val, 15));
    t12 = sat_s32(txy + scale_shift(ss, r_val, 16));
    sq = magnitude(t11) * magnitude(t11) + magnitude(t22) * magnitude(t22);
    c2 = magnitude(t12) * magnitude(t12);
    if (c2 > 64'hffffffffffffffff / 2) tot = 64'hffffffffffffffff;
    else if (sq > 64'hffffffffffffffff - 2 * c2) tot = 64'hffffffffffffffff;
    else tot = sq + 2 * c2;
    n = int_root(tot);
    yld = n >= yld_val;
    frac = 0;
    den = r_val + mu_val;
    g11 = 0; g22 = 0; g12 = 0; nm11 = 0; nm22 = 0; nm12 = 0;
    if (yld && n != 0) frac = ((n - yld_val) << 31) / n;
    if (p.kind == bpsu_pkg::KIND_CENTER) begin
      if (yld) begin
        g11 = shrink_strain(t11, frac, den);
        g22 = shrink_strain(t22, frac, den);
      end
      d11 = exx - g11;
      d22 = eyy - g22;
      nm11 = sat_s32(txx + scale_shift(d11, rho_val, 15));
      nm22 = sat_s32(tyy + scale_shift(d22, rho_val, 15));
      resid = magnitude(d11) > magnitude(d22) ? magnitude(d11) : magnitude(d22);
    end else begin
      if (yld) g12 = shrink_strain(t12, frac, den);
      e = ss - 2 * g12;
      nm12 = sat_s32(txy + scale_shift(e, rho_val, 16));
      resid = magnitude(e) >> 1;
    end
    u.gxx = g11[31:0]; u.gyy = g22[31:0]; u.gxy = g12[31:0];
    u.nxx = nm11[31:0]; u.nyy = nm22[31:0]; u.nxy = nm12[31:0];
    u.norm = n > 64'h7fffffff ? 31'h7fffffff : n[30:0];
    u.yld = yld;
    u.resid = resid > 64'h7fffffff ? 31'h7fffffff : resid[30:0];
    return u;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
      2: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      3: case ($urandom_range(0, 3))
           0: return PMAX;
           1: return NMAX;
           2: return 32'hffffffff;
           default: return 32'h0;
         endcase
      default: return 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
    endcase
  endfunction

  task automatic write_reg(bpsu_pkg::cfg_reg_t idx, longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    @(posedge clk);
    case (idx)
      bpsu_pkg::REG_PENALTY_R: r_val = 64'(val[30:0]);
      bpsu_pkg::REG_VISCOSITY: mu_val = 64'(val[30:0]);
      bpsu_pkg::REG_YIELD:     yld_val = 64'(val[30:0]);
      default:                 rho_val = 64'(val[30:0]);
    endcase
  endtask

  task automatic set_params(longint unsigned r, longint unsigned mu,
                            longint unsigned y, longint unsigned rho);
    write_reg(bpsu_pkg::REG_PENALTY_R, r);
    write_reg(bpsu_pkg::REG_VISCOSITY, mu);
    write_reg(bpsu_pkg::REG_YIELD, y);
    write_reg(bpsu_pkg::REG_STEP_RHO, rho);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(point_t p, bit zero_known);
    result_t u, z;
    while (!no_idle && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= p.kind;
    s_tdata <= {p.ssum, p.eyy, p.exx, p.txy, p.tyy, p.txx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    u = shrinkage_update(p);
    if (zero_known) begin
      // zero point with zero yield stress: all values zero, norm counts as yielded
      z = '0;
      z.yld = 1'b1;
      if (u != z) begin
        $error("zero point predicted nonzero");
        fails++;
      end
      u = z;
    end
    pending_updates = {pending_updates, u};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic random_points(int count);
    point_t p;
    repeat (count) begin
      p.kind = 1'($urandom_range(0, 1));
      p.txx = rand_word(); p.tyy = rand_word(); p.txy = rand_word();
      p.exx = rand_word(); p.eyy = rand_word(); p.ssum = rand_word();
      send_point(p, 1'b0);
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    m_tready <= sink_on && (no_idle || $urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    result_t u;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_updates.size() == 0) begin
        $error("unexpected result transaction");
        fails++;
      end else begin
        u = pending_updates.pop_front();
        check_field("plastic_xx", u.gxx, m_tdata[31:0]);
        check_field("plastic_yy", u.gyy, m_tdata[63:32]);
        check_field("plastic_xy", u.gxy, m_tdata[95:64]);
        check_field("new_mult_xx", u.nxx, m_tdata[127:96]);
        check_field("new_mult_yy", u.nyy, m_tdata[159:128]);
        check_field("new_mult_xy", u.nxy, m_tdata[191:160]);
        check_field("trial_norm", {1'b0, u.norm}, {1'b0, m_tdata[222:192]});
        check_field("yielded", {31'b0, u.yld}, {31'b0, m_tdata[223]});
        check_field("residual", {1'b0, u.resid}, {1'b0, m_tdata[254:224]});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sink_on <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[k]) send_point(dir_tab[k].p, dir_tab[k].zero_known);
    random_points(300);
    drain();
    // no shrink denominator, everything yields
    set_params(0, 0, 0, 64'h7fffffff);
    random_points(300);
    drain();
    set_params(64'h7fffffff, 64'h7fffffff, 64'h7fffffff, 0);
    random_points(300);
    drain();
    no_idle = 1'b1;
    set_params(64'h10000, 64'h8000, 64'h20000, 64'h10000);
    random_points(350);
    drain();
    no_idle = 1'b0;
    set_params($urandom_range(0, 32'h40000), $urandom_range(0, 32'h40000),
               $urandom_range(0, 32'h100000), $urandom_range(0, 32'h40000));
    random_points(350);
    drain();
    set_params($urandom() >> 1, $urandom() >> 1, $urandom() >> 1, $urandom() >> 1);
    random_points(340);
    drain();
    repeat (bpsu_pkg::PIPE_DEPTH + 10) @(posedge clk);
    if (fails == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== bingham_plastic_shrinkage_update.f =====
hw/rtl/bpsu_pkg.sv
hw/rtl/bingham_plastic_shrinkage_update.sv
tb/sv/tb.sv
